[hw/rtl/clr_pkg.sv]
// Shared constants for the clipped line rasterizer.
`default_nettype none

package clr_pkg;

    // Fixed field widths
    localparam int COLOR_BITS  = 16;
    localparam int SCREEN_BITS = 11;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    // Screen size after reset
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 11'd480;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 11'd320;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/clr_engine.sv]
// Line setup and per-point Bresenham stepper with on-screen test.
`default_nettype none

module clr_engine #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_fire,
    input  wire logic                              in_cmd,
    input  wire logic [COORD_BITS-1:0]             start_x,
    input  wire logic [COORD_BITS-1:0]             start_y,
    input  wire logic [COORD_BITS-1:0]             end_x,
    input  wire logic [COORD_BITS-1:0]             end_y,
    input  wire logic [clr_pkg::COLOR_BITS-1:0]    line_color,
    input  wire logic [clr_pkg::SCREEN_BITS-1:0]   screen_width,
    input  wire logic [clr_pkg::SCREEN_BITS-1:0]   screen_height,
    output logic                                   res_valid,
    output logic [COORD_BITS-1:0]                  res_x,
    output logic [COORD_BITS-1:0]                  res_y,
    output logic [clr_pkg::COLOR_BITS-1:0]         res_color,
    output logic                                   res_on_screen,
    output logic                                   res_last
);
    import clr_pkg::*;

    localparam int LEN_W = COORD_BITS + 1;
    localparam int CMP_W = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;

    // Line state
    logic                    active_reg, active_next;
    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]   err_reg, err_next;
    logic [COORD_BITS-1:0]   major_reg, major_next;
    logic [COORD_BITS-1:0]   minor_reg, minor_next;
    logic [LEN_W-1:0]        left_reg, left_next;
    logic                    step_x_en_reg, step_x_en_next;
    logic                    step_x_neg_reg, step_x_neg_next;
    logic                    step_y_en_reg, step_y_en_next;
    logic                    major_is_y_reg, major_is_y_next;
    logic [COLOR_BITS-1:0]   color_reg, color_next;

    // Setup datapath
    logic signed [LEN_W-1:0] x1_ext, y1_ext, x2_ext, y2_ext;
    logic signed [LEN_W-1:0] dx, dy, dx_n, dy_n, ax_full;
    logic                    swap;
    logic [COORD_BITS-1:0]   ax, ay;

    // Step datapath
    logic [LEN_W-1:0]        err_sum;
    logic [LEN_W-1:0]        err_sub;
    logic                    minor_step;
    logic [COORD_BITS-1:0]   x_inc, y_inc;
    logic                    x_in, y_in;

    // Order the endpoints so y never decreases, then take extents
    always_comb begin
        x1_ext  = {start_x[COORD_BITS-1], start_x};
        y1_ext  = {start_y[COORD_BITS-1], start_y};
        x2_ext  = {end_x[COORD_BITS-1], end_x};
        y2_ext  = {end_y[COORD_BITS-1], end_y};
        dx      = x2_ext - x1_ext;
        dy      = y2_ext - y1_ext;
        swap    = dy[LEN_W-1] || ((dy == '0) && dx[LEN_W-1]);
        dx_n    = swap ? -dx : dx;
        dy_n    = swap ? -dy : dy;
        ax_full = dx_n[LEN_W-1] ? -dx_n : dx_n;
        ax      = ax_full[COORD_BITS-1:0];
        ay      = dy_n[COORD_BITS-1:0];
    end

    // Error term and per-axis increments for the current point
    always_comb begin
        err_sum    = {1'b0, err_reg} + {1'b0, minor_reg};
        err_sub    = err_sum - {1'b0, major_reg};
        minor_step = (err_sum >= {1'b0, major_reg});
        x_inc      = step_x_en_reg ? (step_x_neg_reg ? '1 : COORD_BITS'(1)) : '0;
        y_inc      = step_y_en_reg ? COORD_BITS'(1) : '0;
    end

    // Next state
    always_comb begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_next        = err_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        left_next       = left_reg;
        step_x_en_next  = step_x_en_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_en_next  = step_y_en_reg;
        major_is_y_next = major_is_y_reg;
        color_next      = color_reg;
        if (in_fire && (in_cmd == CMD_START)) begin
            major_is_y_next = (ax < ay);
            major_next      = (ax < ay) ? ay : ax;
            minor_next      = (ax < ay) ? ax : ay;
            err_next        = ((ax < ay) ? ax : ay) >> 1;
            left_next       = {1'b0, ((ax < ay) ? ay : ax)} + LEN_W'(1);
            cur_x_next      = swap ? end_x : start_x;
            cur_y_next      = swap ? end_y : start_y;
            step_x_en_next  = (dx_n != '0);
            step_x_neg_next = dx_n[LEN_W-1];
            step_y_en_next  = (dy_n != '0);
            color_next      = line_color;
            active_next     = 1'b1;
        end else if (in_fire && active_reg) begin
            if (minor_step) begin
                err_next   = err_sub[COORD_BITS-1:0];
                cur_x_next = cur_x_reg + x_inc;
                cur_y_next = cur_y_reg + y_inc;
            end else begin
                err_next = err_sum[COORD_BITS-1:0];
                if (major_is_y_reg) begin
                    cur_y_next = cur_y_reg + y_inc;
                end else begin
                    cur_x_next = cur_x_reg + x_inc;
                end
            end
            left_next = left_reg - LEN_W'(1);
            if (left_reg == LEN_W'(1)) begin
                active_next = 1'b0;
            end
        end
    end

    // Only the active flag needs reset; the rest is loaded on start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        err_reg        <= err_next;
        major_reg      <= major_next;
        minor_reg      <= minor_next;
        left_reg       <= left_next;
        step_x_en_reg  <= step_x_en_next;
        step_x_neg_reg <= step_x_neg_next;
        step_y_en_reg  <= step_y_en_next;
        major_is_y_reg <= major_is_y_next;
        color_reg      <= color_next;
    end

    // Emit the current point on a step
    always_comb begin
        x_in = !cur_x_reg[COORD_BITS-1] &&
               (CMP_W'(cur_x_reg) < CMP_W'(screen_width));
        y_in = !cur_y_reg[COORD_BITS-1] &&
               (CMP_W'(cur_y_reg) < CMP_W'(screen_height));
        res_valid     = in_fire && (in_cmd == CMD_STEP) && active_reg;
        res_x         = cur_x_reg;
        res_y         = cur_y_reg;
        res_color     = color_reg;
        res_on_screen = x_in && y_in;
        res_last      = (left_reg == LEN_W'(1));
    end

endmodule

`default_nettype wire

[hw/rtl/clipped_line_rasterizer.sv]
// Clipped line rasterizer: stream interface, screen size registers, output skid.
//
// Usage:
//   Input stream s_*: s_tuser is the command (0 start a line, 1 next point);
//   s_tdata carries the endpoints and color, used only by a start command.
//   Output stream m_*: one point per step command while a line is running.
//   m_tdata holds x, y and color; m_tuser flags an on-screen point; m_tlast
//   marks the final point of the line. A step with no line running and every
//   start command produce nothing.
//   Config channel cfg_*: index 0 sets the screen width, index 1 the height;
//   cfg_ready is always high. Write it only while the block is idle.
// Output path and rate:
//   A step accepted at one edge has its point registered at that edge, in
//   the output register or, with the output stalled, the skid register.
//   Steps and points move at one per clock while s_tready and m_tready are high.
// Reset and stall:
//   aresetn low clears the line and both output stages and restores a
//   480 x 320 screen. When m_tready is low, one extra point is held in a
//   skid register and s_tready drops only once that register is full.
`default_nettype none

module clipped_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    // tdata: start_x, start_y, end_x, end_y, line_color (low bits first)
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    input  wire logic [((4*COORD_BITS+clr_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: cmd
    input  wire logic                                        s_tuser,
    // tdata: point_x, point_y, point_color (low bits first)
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    output logic [((2*COORD_BITS+clr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
    // tuser: on_screen
    output logic                                             m_tuser,
    output logic                                             m_tlast,
    input  wire logic                                        cfg_valid,
    output logic                                             cfg_ready,
    input  wire logic [clr_pkg::CFG_IDX_BITS-1:0]            cfg_index,
    input  wire logic [clr_pkg::SCREEN_BITS-1:0]             cfg_data
);
    import clr_pkg::*;

    localparam int PAY_W = 2*COORD_BITS + COLOR_BITS;
    localparam int MD_W  = ((2*COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int ITEM_W = PAY_W + 2;

    // Screen size registers
    logic [SCREEN_BITS-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_SCREEN_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == CFG_SCREEN_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Line engine
    logic                    in_fire;
    logic                    res_valid;
    logic [COORD_BITS-1:0]   res_x, res_y;
    logic [COLOR_BITS-1:0]   res_color;
    logic                    res_on_screen, res_last;

    assign in_fire = s_tvalid && s_tready;

    clr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .in_cmd        (s_tuser),
        .start_x       (s_tdata[COORD_BITS-1:0]),
        .start_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x         (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y         (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .line_color    (s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .res_valid     (res_valid),
        .res_x         (res_x),
        .res_y         (res_y),
        .res_color     (res_color),
        .res_on_screen (res_on_screen),
        .res_last      (res_last)
    );

    // Output register plus skid register
    logic [ITEM_W-1:0] res_item;
    logic [ITEM_W-1:0] out_item_reg, skid_item_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              out_fire;

    assign res_item = {res_last, res_on_screen, res_color, res_y, res_x};
    assign out_fire = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_item_reg <= skid_item_reg;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_item_reg <= res_item;
            end else begin
                skid_item_reg <= res_item;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MD_W'(out_item_reg[PAY_W-1:0]);
    assign m_tuser  = out_item_reg[PAY_W];
    assign m_tlast  = out_item_reg[PAY_W+1];

    // A held skid point always has a point ahead of it in the output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills when a point arrives while the output is stalled
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!skid_valid_reg && res_valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("stalled point not captured in skid register");

    // A drained output with nothing behind it goes empty
    a_out_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !skid_valid_reg && !res_valid) |=> !out_valid_reg)
        else $error("output register repeated a point");

endmodule

`default_nettype wire
